// File: design/transparent_pixel_color_fill_core_macros.svh
// Assertion macros for the fill core checker
`ifndef TRANSPARENT_PIXEL_COLOR_FILL_CORE_MACROS_SVH
`define TRANSPARENT_PIXEL_COLOR_FILL_CORE_MACROS_SVH

// antecedent implies consequent on the next edge, masked during reset
`define TPCF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tpcf check failed");

// same, but also checked while reset is held
`define TPCF_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tpcf check failed");

`endif

// File: design/tpcf_pkg.sv
package tpcf_pkg;

   localparam int unsigned DEF_MAX_WIDTH = 1024;
   localparam int unsigned MAX_HEIGHT    = 4096;
   localparam int unsigned WIDTH_W       = 11;
   localparam int unsigned HEIGHT_W      = 13;
   localparam int unsigned CHAN_W        = 8;
   localparam int unsigned PIX_W         = 32;
   localparam int unsigned ASUM_W        = 12;
   localparam int unsigned SUM_W         = 20;
   localparam int unsigned IDX_W         = 4;
   localparam int unsigned CSR_IDX_W     = 2;
   localparam int unsigned CSR_DATA_W    = 13;
   localparam int unsigned ACC_LAST      = 8;
   localparam int unsigned DIV_LAST      = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_THRESHOLD = 2'd2;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd1024;

   typedef struct packed {
      logic             latch;
      logic             upd;
      logic             acc;
      logic             div;
      logic             load;
      logic [IDX_W-1:0] idx;
   } tpcf_cmd_type;

   typedef struct packed {
      logic pend_nz;
      logic emit;
      logic out_free;
   } tpcf_status_type;

endpackage

// File: design/tpcf_if.sv
interface tpcf_req_if import tpcf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              is_pixel;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;
   logic [CHAN_W-1:0] alpha_in;

   modport source (output valid, is_pixel, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink (input valid, is_pixel, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface tpcf_rsp_if import tpcf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;
   logic [CHAN_W-1:0] alpha_out;
   logic              frame_end;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                 output ready);
endinterface

// File: design/transparent_pixel_color_fill_core.sv
// A beat whose step completes its window goes through an update step, a neighbourhood sum
// over the window, then a radix-2 divider per channel for the three channels, sharing one
// divisor, then the output state. A beat that yields no result takes only the update step,
// and a drain beat with no tail pending none; no new beat is taken until idle again.
// Reset: synchronous; registers return to width 1024, height 1024, threshold 0, frame
// restarted. Line buffers are not cleared and need no clearing pass.
module transparent_pixel_color_fill_core import tpcf_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   tpcf_req_if.sink              req_ch,
   tpcf_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tpcf_cmd_type    cmd;
   tpcf_status_type status;

   tpcf_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_is_pixel (req_ch.is_pixel),
      .req_ready    (req_ch.ready),
      .status       (status),
      .cmd          (cmd)
   );

   tpcf_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_red       (req_ch.red_in),
      .req_green     (req_ch.green_in),
      .req_blue      (req_ch.blue_in),
      .req_alpha     (req_ch.alpha_in),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_red       (rsp_ch.red_out),
      .rsp_green     (rsp_ch.green_out),
      .rsp_blue      (rsp_ch.blue_out),
      .rsp_alpha     (rsp_ch.alpha_out),
      .rsp_frame_end (rsp_ch.frame_end)
   );

endmodule

// File: design/tpcf_ctrl.sv
module tpcf_ctrl import tpcf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_is_pixel,
   output logic            req_ready,
   input  tpcf_status_type status,
   output tpcf_cmd_type    cmd
);

   typedef enum logic [2:0] {S_IDLE, S_UPD, S_ACC, S_DIV, S_OUT} state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd       = '0;
      cmd.latch = accept;
      cmd.upd   = (state_ff == S_UPD);
      cmd.acc   = (state_ff == S_ACC);
      cmd.div   = (state_ff == S_DIV);
      cmd.load  = (state_ff == S_OUT) && status.out_free;
      cmd.idx   = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               idx_ff <= '0;
               if (accept && (status.pend_nz || req_is_pixel)) begin
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               idx_ff   <= '0;
               state_ff <= status.emit ? S_ACC : S_IDLE;
            end
            S_ACC: begin
               if (idx_ff == IDX_W'(ACC_LAST)) begin
                  idx_ff   <= '0;
                  state_ff <= S_DIV;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_DIV: begin
               if (idx_ff == IDX_W'(DIV_LAST)) begin
                  idx_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_OUT: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: design/tpcf_datapath.sv
module tpcf_datapath import tpcf_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tpcf_cmd_type          cmd,
   output tpcf_status_type       status,
   input  logic [CHAN_W-1:0]     req_red,
   input  logic [CHAN_W-1:0]     req_green,
   input  logic [CHAN_W-1:0]     req_blue,
   input  logic [CHAN_W-1:0]     req_alpha,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [CHAN_W-1:0]     rsp_red,
   output logic [CHAN_W-1:0]     rsp_green,
   output logic [CHAN_W-1:0]     rsp_blue,
   output logic [CHAN_W-1:0]     rsp_alpha,
   output logic                  rsp_frame_end
);

   localparam int unsigned AW     = $clog2(MAX_WIDTH);
   localparam int unsigned CW     = $clog2(MAX_WIDTH + 1);
   localparam int unsigned PW     = $clog2(MAX_WIDTH + 2);
   localparam int unsigned CENTRE = 4;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [CHAN_W-1:0]   thresh_ff;
   logic [CW-1:0]       col_ff;
   logic [HEIGHT_W-1:0] row_ff;
   logic [PW-1:0]       pend_ff;
   logic [PIX_W-1:0]    window_ff [9];
   logic [PIX_W-1:0]    pix_ff;
   logic                drain_ff;
   logic [PIX_W-1:0]    rd_up_ff;
   logic [PIX_W-1:0]    rd_mid_ff;
   logic                left_ok_ff, right_ok_ff, top_ok_ff, bot_ok_ff, fend_ff;
   logic [ASUM_W-1:0]   ss_ff;
   logic [SUM_W-1:0]    rem_ff [3];
   logic [CHAN_W-1:0]   quo_ff [3];
   logic                rsp_valid_ff;
   logic [CHAN_W-1:0]   out_ff [3];
   logic [CHAN_W-1:0]   out_alpha_ff;
   logic                out_fend_ff;

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic [CW-1:0]       eff_w;
   logic [HEIGHT_W-1:0] eff_h;
   logic                cfg_restart;
   logic                col_zero;
   logic [HEIGHT_W-1:0] cr;
   logic [CW:0]         col_inc;
   logic [PIX_W-1:0]    sel;
   logic [1:0]          wcol, wrow;
   logic                use_px;
   logic [2:0]          sh;
   logic [SUM_W-1:0]    dvs;
   logic                fill;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HEIGHT_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign cfg_restart = csr_we && (csr_index == CSR_IMAGE_WIDTH ||
                                   csr_index == CSR_IMAGE_HEIGHT ||
                                   csr_index == CSR_ALPHA_THRESHOLD);
   assign col_zero    = (col_ff == '0);
   assign cr          = col_zero ? row_ff - HEIGHT_W'(2) : row_ff - HEIGHT_W'(1);
   assign col_inc     = {1'b0, col_ff} + (CW+1)'(1);

   assign status.pend_nz  = (pend_ff != '0);
   assign status.emit     = (row_ff >= HEIGHT_W'(2)) || (row_ff == HEIGHT_W'(1) && !col_zero);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // line buffers
   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         upper_mem[col_ff[AW-1:0]]  <= rd_mid_ff;
         middle_mem[col_ff[AW-1:0]] <= pix_ff;
      end
      rd_up_ff  <= upper_mem[col_ff[AW-1:0]];
      rd_mid_ff <= middle_mem[col_ff[AW-1:0]];
   end

   // position, config and window
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         thresh_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else if (cfg_restart) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default:          thresh_ff <= csr_wdata[CHAN_W-1:0];
         endcase
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else if (cmd.upd) begin
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= window_ff[i+3];
         end
         window_ff[6] <= rd_up_ff;
         window_ff[7] <= rd_mid_ff;
         window_ff[8] <= pix_ff;
         if (col_inc >= {1'b0, eff_w}) begin
            col_ff <= '0;
            row_ff <= row_ff + HEIGHT_W'(1);
         end else begin
            col_ff <= col_inc[CW-1:0];
         end
         if (drain_ff) begin
            pend_ff <= pend_ff - PW'(1);
            if (pend_ff == PW'(1)) begin
               col_ff <= '0;
               row_ff <= '0;
            end
         end else if (row_ff == eff_h - HEIGHT_W'(1) && col_ff == eff_w - CW'(1)) begin
            pend_ff <= PW'(eff_w) + PW'(1);
         end
      end
   end

   always_comb begin
      sel = window_ff[cmd.idx];
      case (cmd.idx)
         4'd0, 4'd1, 4'd2: wcol = 2'd0;
         4'd3, 4'd4, 4'd5: wcol = 2'd1;
         default:          wcol = 2'd2;
      endcase
      case (cmd.idx)
         4'd0, 4'd3, 4'd6: wrow = 2'd0;
         4'd1, 4'd4, 4'd7: wrow = 2'd1;
         default:          wrow = 2'd2;
      endcase
      use_px = (wcol != 2'd0 || left_ok_ff) && (wcol != 2'd2 || right_ok_ff) &&
               (wrow != 2'd0 || top_ok_ff) && (wrow != 2'd2 || bot_ok_ff) &&
               (sel[31:24] > thresh_ff);
      sh     = 3'(3'd7 - cmd.idx[2:0]);
      dvs    = SUM_W'(ss_ff) << sh;
      fill   = (window_ff[CENTRE][31:24] <= thresh_ff) && (ss_ff != '0);
   end

   // neighbourhood sums, then restoring division in place
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         pix_ff   <= status.pend_nz ? '0 : {req_alpha, req_blue, req_green, req_red};
         drain_ff <= status.pend_nz;
      end
      if (cmd.upd) begin
         left_ok_ff  <= col_zero ? (eff_w != CW'(1)) : (col_ff != CW'(1));
         right_ok_ff <= !col_zero;
         top_ok_ff   <= (cr != '0);
         bot_ok_ff   <= ({1'b0, cr} + (HEIGHT_W+1)'(1)) < {1'b0, eff_h};
         fend_ff     <= drain_ff && (pend_ff == PW'(1));
         ss_ff       <= '0;
         for (int ch = 0; ch < 3; ch++) begin
            rem_ff[ch] <= '0;
            quo_ff[ch] <= '0;
         end
      end else if (cmd.acc) begin
         if (use_px) begin
            ss_ff <= ss_ff + ASUM_W'(sel[31:24]);
            for (int ch = 0; ch < 3; ch++) begin
               rem_ff[ch] <= rem_ff[ch] +
                             SUM_W'({8'd0, sel[31:24]} * {8'd0, sel[8*ch +: 8]});
            end
         end
      end else if (cmd.div) begin
         for (int ch = 0; ch < 3; ch++) begin
            if (rem_ff[ch] >= dvs) begin
               rem_ff[ch]     <= rem_ff[ch] - dvs;
               quo_ff[ch][sh] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int ch = 0; ch < 3; ch++) begin
            out_ff[ch] <= fill ? quo_ff[ch] : window_ff[CENTRE][8*ch +: 8];
         end
         out_alpha_ff <= window_ff[CENTRE][31:24];
         out_fend_ff  <= fend_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = out_ff[0];
   assign rsp_green     = out_ff[1];
   assign rsp_blue      = out_ff[2];
   assign rsp_alpha     = out_alpha_ff;
   assign rsp_frame_end = out_fend_ff;

endmodule

// File: design/tpcf_checker.sv
`include "transparent_pixel_color_fill_core_macros.svh"

module tpcf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_is_pixel,
   input logic rsp_valid,
   input logic rsp_ready
);

   `TPCF_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, reset, !rsp_valid)
   `TPCF_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)
   `TPCF_ASSERT_NEXT(a_pixel_busy, req_valid && req_ready && req_is_pixel, !req_ready)
   `TPCF_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid))

endmodule

bind transparent_pixel_color_fill_core tpcf_checker u_tpcf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_is_pixel (req_ch.is_pixel),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready)
);

// File: tb/sv/tpcf_fill_checker.sv
`timescale 1ns / 1ps
module tpcf_fill_checker import tpcf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tpcf_req_if                   req,
   tpcf_rsp_if                   rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    owed_count,
   output int                    pixels_seen
);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              fend;
   } fill_pixel_type;

   fill_pixel_type            owed_pixels[$];
   logic [WIDTH_W-1:0]        cfg_width;
   logic [HEIGHT_W-1:0]       cfg_height;
   logic [CHAN_W-1:0]         cfg_thr;
   logic [PIX_W-1:0]          upper_buf[DEF_MAX_WIDTH];
   logic [PIX_W-1:0]          middle_buf[DEF_MAX_WIDTH];
   logic [PIX_W-1:0]          win[9];
   int unsigned               col, row, tail;

   function automatic int unsigned eff_w();
      if (cfg_width == 0) return 1;
      if (cfg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return 32'(cfg_width);
   endfunction

   function automatic int unsigned eff_h();
      if (cfg_height == 0) return 1;
      if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(cfg_height);
   endfunction

   function automatic void restart();
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      tail = 0;
   endfunction

   function automatic void fill_pixel(int unsigned cs, bit has_right, int unsigned co,
                                      int unsigned cr, bit fend);
      fill_pixel_type    px;
      logic [PIX_W-1:0]  ctr, p;
      int unsigned       ss, sr, sg, sb, pa;
      ctr = win[cs*3+1];
      px.red   = ctr[7:0];
      px.green = ctr[15:8];
      px.blue  = ctr[23:16];
      px.alpha = ctr[31:24];
      px.fend  = fend;
      if (px.alpha <= cfg_thr) begin
         ss = 0; sr = 0; sg = 0; sb = 0;
         for (int s = 0; s < 3; s++) begin
            if (s == 0 && co == 0) continue;
            if (s == 2 && !has_right) continue;
            for (int k = 0; k < 3; k++) begin
               if (k == 0 && cr == 0) continue;
               if (k == 2 && cr + 1 >= eff_h()) continue;
               p = win[(cs+s-1)*3+k];
               pa = 32'(p[31:24]);
               if (pa <= cfg_thr) continue;
               ss += pa;
               sr += pa * p[7:0];
               sg += pa * p[15:8];
               sb += pa * p[23:16];
            end
         end
         if (ss > 0) begin
            px.red   = 8'(sr / ss);
            px.green = 8'(sg / ss);
            px.blue  = 8'(sb / ss);
         end
      end
      owed_pixels.push_back(px);
   endfunction

   function automatic void shift_window(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                        logic [PIX_W-1:0] b);
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = t;
      win[7] = m;
      win[8] = b;
   endfunction

   function automatic void advance(logic [PIX_W-1:0] pix, bit fend);
      int unsigned      w, c, r;
      bit               emit;
      logic [PIX_W-1:0] t, m;
      w = eff_w();
      c = col;
      r = row;
      emit = (r >= 2) || (r == 1 && c >= 1);
      if (c >= w) c = 0;
      t = upper_buf[c];
      m = middle_buf[c];
      upper_buf[c] = m;
      middle_buf[c] = pix;
      if (c == 0) begin
         if (emit) fill_pixel(2, 1'b0, w - 1, r - 2, fend);
         shift_window(t, m, pix);
      end else begin
         shift_window(t, m, pix);
         if (emit) fill_pixel(1, 1'b1, c - 1, r - 1, fend);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      col = c;
      row = r;
   endfunction

   function automatic void take_beat(bit is_pix, logic [PIX_W-1:0] pix);
      bit fin;
      if (tail > 0) begin
         tail--;
         advance('0, tail == 0);
         if (tail == 0) begin
            col = 0;
            row = 0;
         end
         return;
      end
      if (!is_pix) return;
      fin = (row == eff_h() - 1) && (col == eff_w() - 1);
      advance(pix, 1'b0);
      if (fin) tail = eff_w() + 1;
   endfunction

   always @(posedge clock) begin
      fill_pixel_type exp_px, got;
      if (reset) begin
         cfg_width   = RESET_WIDTH;
         cfg_height  = RESET_HEIGHT;
         cfg_thr     = '0;
         foreach (upper_buf[i]) upper_buf[i] = '0;
         foreach (middle_buf[i]) middle_buf[i] = '0;
         restart();
         owed_pixels.delete();
         fail_count  = 0;
         pixels_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  cfg_width = csr_wdata[WIDTH_W-1:0];
                  restart();
               end
               CSR_IMAGE_HEIGHT: begin
                  cfg_height = csr_wdata[HEIGHT_W-1:0];
                  restart();
               end
               CSR_ALPHA_THRESHOLD: begin
                  cfg_thr = csr_wdata[CHAN_W-1:0];
                  restart();
               end
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            take_beat(req.is_pixel, {req.alpha_in, req.blue_in, req.green_in, req.red_in});
         if (rsp.valid && rsp.ready) begin
            got = {rsp.red_out, rsp.green_out, rsp.blue_out, rsp.alpha_out, rsp.frame_end};
            pixels_seen++;
            if (owed_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat %h", got);
            end else begin
               exp_px = owed_pixels.pop_front();
               if (got !== exp_px) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp r%h g%h b%h a%h fe%b, got r%h g%h b%h a%h fe%b",
                              exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                              exp_px.fend, got.red, got.green, got.blue, got.alpha,
                              got.fend);
               end
            end
         end
      end
      owed_count = owed_pixels.size();
   end

endmodule

// File: tb/sv/tb_transparent_pixel_color_fill_core.sv
`timescale 1ns / 1ps
module tb_transparent_pixel_color_fill_core;
   import tpcf_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count, owed_count, pixels_seen;
   int                    beats_sent, frames_run, send_idle, recv_idle;
   logic [CHAN_W-1:0]     cur_thr;

   tpcf_req_if req_ch();
   tpcf_rsp_if rsp_ch();

   transparent_pixel_color_fill_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tpcf_fill_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .owed_count  (owed_count),
      .pixels_seen (pixels_seen)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_ALPHA_THRESHOLD) cur_thr = val[CHAN_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_beat(bit is_pix, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
      bit got;
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.is_pixel <= is_pix;
      req_ch.red_in   <= r;
      req_ch.green_in <= g;
      req_ch.blue_in  <= b;
      req_ch.alpha_in <= a;
      do begin
         @(negedge clock);
         got = req_ch.ready;
         @(posedge clock);
      end while (!got);
      beats_sent++;
   endtask

   function automatic logic [CHAN_W-1:0] pick_alpha();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd255;
         2: return cur_thr;
         3: return cur_thr + 8'd1;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random_pixel();
      send_beat(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), pick_alpha());
   endtask

   // w*h pixels then the tail drain; a cut frame stops early and is restarted by the next write
   task automatic run_frame(int w, int h, bit cut);
      int n;
      n = w * h;
      if (cut) n = $urandom_range(n > 1 ? n - 1 : 1);
      frames_run++;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0)
            send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         send_random_pixel();
      end
      if (!cut)
         for (int i = 0; i < w + 1 + $urandom_range(2); i++)
            send_beat($urandom_range(3) == 0, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
   endtask

   task automatic set_frame(int w, int h, int thr);
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_ALPHA_THRESHOLD, CSR_DATA_W'(thr));
   endtask

   initial begin
      int w, h;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.is_pixel = 1'b0;
      req_ch.red_in   = '0;
      req_ch.green_in = '0;
      req_ch.blue_in  = '0;
      req_ch.alpha_in = '0;
      rsp_ch.ready    = 1'b0;
      send_idle       = 38;
      recv_idle       = 45;
      beats_sent      = 0;
      frames_run      = 0;
      cur_thr         = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // drain with nothing pending, then a 3x3 frame with extreme channels
      send_beat(1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
      set_frame(3, 3, 100);
      send_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd0);
      send_beat(1'b1, 8'hff, 8'hff, 8'hff, 8'd255);
      send_beat(1'b1, 8'h12, 8'hff, 8'h00, 8'd100);
      send_beat(1'b1, 8'hff, 8'h00, 8'hff, 8'd101);
      send_beat(1'b1, 8'h80, 8'h40, 8'h20, 8'd0);
      send_beat(1'b1, 8'h00, 8'hff, 8'h7f, 8'd255);
      send_beat(1'b1, 8'h55, 8'haa, 8'h55, 8'd0);
      send_beat(1'b1, 8'h01, 8'hfe, 8'h01, 8'd100);
      send_beat(1'b1, 8'hff, 8'hff, 8'hff, 8'd0);
      send_beat(1'b1, 8'hab, 8'hcd, 8'hef, 8'd200);
      send_beat(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      // width 0 and height 0 act as a single pixel; threshold 255 makes all transparent
      set_frame(0, 0, 255);
      send_beat(1'b1, 8'h10, 8'h20, 8'h30, 8'hff);
      send_beat(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      // oversized registers clamp; part of a tall frame only
      set_frame(2047, 8191, 0);
      set_frame(1, 8191, 0);
      run_frame(1, 12, 1'b1);

      // everything accepted so far must drain before the next beat
      settle();

      while (beats_sent < 850) begin
         if (beats_sent > 600) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (beats_sent > 300) begin
            send_idle = 45;
            recv_idle = 38;
         end
         w = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
         h = $urandom_range(5, 1);
         case ($urandom_range(3))
            0: set_frame(w, h, $urandom_range(255));
            1: set_frame(w, h, int'(cur_thr));
            default: begin
               write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
               write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
            end
         endcase
         run_frame(w, h, $urandom_range(7) == 0);
      end

      settle();
      $display("%0d beats over %0d frames, %0d result beats checked, widths 1 to 40",
               beats_sent, frames_run, pixels_seen);
      if (fail_count == 0)
         $display("tb_transparent_pixel_color_fill_core: clean");
      else
         $display("tb_transparent_pixel_color_fill_core: errors");
      $finish;
   end

   initial begin
      #50ms;
      $display("timeout");
      $display("tb_transparent_pixel_color_fill_core: errors");
      $finish;
   end

endmodule
